### rtl/tsph_pkg.sv
// Shared types and constants for the seed text parse-or-hash block.
// Used by the front classifier, the request queue and the back engine.
package tsph_pkg;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       last_byte;
      logic       empty_text;
      logic       blank;
      logic       digit;
      logic       plus;
      logic       minus;
   } item_type;

endpackage

### rtl/text_seed_parse_or_hash.sv
// Seed text parse-or-hash top level: front classifier, request queue, back engine.
// Throughput: one request per cycle while req_stall is low.
// The result of a text reaches the result register once the request marked last has passed
// through the queue and the back engine update; a response stall holds it back.
// Reset (synchronous, active high) empties the queue and clears all text state.
// Depends on tsph_pkg, tsph_front, tsph_fifo and tsph_back.
module text_seed_parse_or_hash #(
   parameter int QUEUE_DEPTH = tsph_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_text_byte,
   input  logic        req_last_byte,
   input  logic        req_empty_text,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_seed,
   output logic        rsp_seed_present,
   output logic        rsp_seed_source
);

   tsph_pkg::item_type push_data;
   tsph_pkg::item_type pop_data;
   logic               push;
   logic               queue_full;
   logic               pop_valid;
   logic               pop;

   tsph_front u_front (
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_text_byte  (req_text_byte),
      .req_last_byte  (req_last_byte),
      .req_empty_text (req_empty_text),
      .queue_full     (queue_full),
      .push           (push),
      .push_data      (push_data)
   );

   tsph_fifo #(
      .Depth (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop_valid (pop_valid),
      .pop_data  (pop_data),
      .pop       (pop)
   );

   tsph_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (pop_valid),
      .q_data           (pop_data),
      .q_pop            (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_seed         (rsp_seed),
      .rsp_seed_present (rsp_seed_present),
      .rsp_seed_source  (rsp_seed_source)
   );

endmodule

### rtl/tsph_front.sv
// Front end: accepts requests and classifies each byte before queueing.
// Depends on tsph_pkg for the queued item type and character codes.
module tsph_front (
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_text_byte,
   input  logic               req_last_byte,
   input  logic               req_empty_text,
   input  logic               queue_full,
   output logic               push,
   output tsph_pkg::item_type push_data
);

   assign req_stall = queue_full;
   assign push      = req_valid & ~queue_full;

   always_comb begin
      push_data.text_byte  = req_text_byte;
      push_data.last_byte  = req_last_byte;
      push_data.empty_text = req_empty_text;
      push_data.blank      = (req_text_byte == tsph_pkg::CHAR_SPACE) ||
                             (req_text_byte == tsph_pkg::CHAR_TAB);
      push_data.digit      = (req_text_byte >= tsph_pkg::CHAR_ZERO) &&
                             (req_text_byte <= tsph_pkg::CHAR_NINE);
      push_data.plus       = (req_text_byte == tsph_pkg::CHAR_PLUS);
      push_data.minus      = (req_text_byte == tsph_pkg::CHAR_MINUS);
   end

endmodule

### rtl/tsph_fifo.sv
// Short request queue between the front classifier and the back engine.
// Depends on tsph_pkg for the item type and the default depth.
module tsph_fifo #(
   parameter int Depth = tsph_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  tsph_pkg::item_type push_data,
   output logic               full,
   output logic               pop_valid,
   output tsph_pkg::item_type pop_data,
   input  logic               pop
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   tsph_pkg::item_type mem_ff [Depth];
   logic [PtrW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]    count_ff, count_in;
   logic               push_ok, pop_ok;

   assign full      = (count_ff == CntW'(Depth));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];
   assign push_ok   = push & ~full;
   assign pop_ok    = pop & pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/tsph_back.sv
// Back engine: trim tracking, lenient UTF-8 decode, string hash and decimal parse,
// plus the result register. Depends on tsph_pkg for the queued item type.
module tsph_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  tsph_pkg::item_type q_data,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [63:0]        rsp_seed,
   output logic               rsp_seed_present,
   output logic               rsp_seed_source
);

   localparam logic ST_RUN    = 1'b0;
   localparam logic ST_FINISH = 1'b1;

   localparam logic [1:0] PH_START  = 2'd0;
   localparam logic [1:0] PH_PLUS   = 2'd1;
   localparam logic [1:0] PH_MINUS  = 2'd2;
   localparam logic [1:0] PH_DIGITS = 2'd3;

   localparam logic [63:0] MAG_Q     = 64'd922337203685477580;
   localparam logic [3:0]  POS_REM   = 4'd7;
   localparam logic [3:0]  NEG_REM   = 4'd8;
   localparam logic [20:0] PLANE_ONE = 21'h10000;
   localparam logic [31:0] HI_BASE   = 32'hD800;
   localparam logic [31:0] LO_BASE   = 32'hDC00;

   function automatic logic [31:0] hash_step(input logic [31:0] h, input logic [20:0] cp);
      logic [20:0] v;
      logic [31:0] hi;
      logic [31:0] lo;
      v  = cp - PLANE_ONE;
      hi = HI_BASE + {21'd0, v[20:10]};
      lo = LO_BASE + {22'd0, v[9:0]};
      if (cp >= PLANE_ONE) begin
         hash_step = (h << 10) - (h << 6) + h + (hi << 5) - hi + lo;
      end else begin
         hash_step = (h << 5) - h + {11'd0, cp};
      end
   endfunction

   function automatic logic [2:0] group_length(input logic [7:0] lead);
      if (lead >= 8'hF0) begin
         group_length = 3'd4;
      end else if (lead >= 8'hE0) begin
         group_length = 3'd3;
      end else if (lead >= 8'hC0) begin
         group_length = 3'd2;
      end else begin
         group_length = 3'd1;
      end
   endfunction

   function automatic logic [20:0] decode_form(input logic [2:0] n, input logic [7:0] b0,
                                               input logic [7:0] b1, input logic [7:0] b2,
                                               input logic [7:0] b3);
      if (n >= 3'd4) begin
         decode_form = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
      end else if (n == 3'd3) begin
         decode_form = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
      end else if (n == 3'd2) begin
         decode_form = {10'd0, b0[4:0], b1[5:0]};
      end else begin
         decode_form = {13'd0, b0};
      end
   endfunction

   logic        state_ff, state_in;
   logic [31:0] hash_ff, hash_in;
   logic [7:0]  la_ff [3];
   logic [7:0]  la_in [3];
   logic [1:0]  cnt_ff, cnt_in;
   logic [31:0] saved_hash_ff, saved_hash_in;
   logic [7:0]  saved_la_ff [3];
   logic [7:0]  saved_la_in [3];
   logic [1:0]  saved_cnt_ff, saved_cnt_in;
   logic        started_ff, started_in;
   logic        space_ff, space_in;
   logic [1:0]  phase_ff, phase_in;
   logic        num_valid_ff, num_valid_in;
   logic        neg_ff, neg_in;
   logic [63:0] mag_ff, mag_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_seed_ff;
   logic        rsp_present_ff;
   logic        rsp_source_ff;
   logic        rsp_load;

   logic [7:0]  b;
   logic [31:0] dec_hash;
   logic [7:0]  dec_la [3];
   logic [1:0]  dec_cnt;
   logic [2:0]  feed_len;
   logic [20:0] feed_cp;

   logic        num_valid_eff;
   logic        num_valid_n, neg_n;
   logic [1:0]  phase_n;
   logic [63:0] mag_n, mag_x10;
   logic        ovf;

   logic [31:0] t_hash, t_final;
   logic [1:0]  t_cnt;
   logic [7:0]  t_b0, t_b1, t_b2;
   logic [63:0] res_seed;
   logic        res_present, res_source;

   assign b = q_data.text_byte;

   always_comb begin
      dec_hash = hash_ff;
      dec_la   = la_ff;
      dec_cnt  = cnt_ff;
      feed_len = group_length(la_ff[0]);
      feed_cp  = '0;
      if (cnt_ff == 2'd0) begin
         if (group_length(b) == 3'd1) begin
            dec_hash = hash_step(hash_ff, {13'd0, b});
         end else begin
            dec_la[0] = b;
            dec_cnt   = 2'd1;
         end
      end else if (({1'b0, cnt_ff} + 3'd1) >= feed_len) begin
         case (feed_len)
            3'd4: feed_cp = decode_form(3'd4, la_ff[0], la_ff[1], la_ff[2], b);
            3'd3: feed_cp = decode_form(3'd3, la_ff[0], la_ff[1], b, 8'd0);
            default: feed_cp = decode_form(3'd2, la_ff[0], b, 8'd0, 8'd0);
         endcase
         dec_hash = hash_step(hash_ff, feed_cp);
         dec_cnt  = 2'd0;
      end else begin
         dec_la[cnt_ff] = b;
         dec_cnt        = cnt_ff + 2'd1;
      end
   end

   always_comb begin
      num_valid_eff = num_valid_ff & ~space_ff;
      num_valid_n   = num_valid_eff;
      phase_n       = phase_ff;
      neg_n         = neg_ff;
      mag_n         = mag_ff;
      mag_x10       = {mag_ff[60:0], 3'b000} + {mag_ff[62:0], 1'b0};
      ovf           = (mag_ff > MAG_Q) ||
                      ((mag_ff == MAG_Q) && (b[3:0] > (neg_ff ? NEG_REM : POS_REM)));
      if (num_valid_eff) begin
         if ((phase_ff == PH_START) && q_data.plus) begin
            phase_n = PH_PLUS;
         end else if (((phase_ff == PH_START) || (phase_ff == PH_PLUS)) && q_data.minus) begin
            neg_n   = 1'b1;
            phase_n = PH_MINUS;
         end else if (q_data.digit) begin
            if (ovf) begin
               num_valid_n = 1'b0;
            end else begin
               mag_n   = mag_x10 + {60'd0, b[3:0]};
               phase_n = PH_DIGITS;
            end
         end else begin
            num_valid_n = 1'b0;
         end
      end
   end

   always_comb begin
      t_hash  = space_ff ? saved_hash_ff : hash_ff;
      t_cnt   = space_ff ? saved_cnt_ff : cnt_ff;
      t_b0    = space_ff ? saved_la_ff[0] : la_ff[0];
      t_b1    = space_ff ? saved_la_ff[1] : la_ff[1];
      t_b2    = space_ff ? saved_la_ff[2] : la_ff[2];
      t_final = (t_cnt != 2'd0) ?
                hash_step(t_hash, decode_form({1'b0, t_cnt}, t_b0, t_b1, t_b2, 8'd0)) : t_hash;
      res_seed    = '0;
      res_present = 1'b0;
      res_source  = 1'b0;
      if (started_ff) begin
         res_present = 1'b1;
         if (num_valid_ff && (phase_ff == PH_DIGITS)) begin
            res_seed = neg_ff ? (64'd0 - mag_ff) : mag_ff;
         end else begin
            res_seed   = {{32{t_final[31]}}, t_final};
            res_source = 1'b1;
         end
      end
   end

   assign rsp_load = (state_ff == ST_FINISH) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in      = state_ff;
      hash_in       = hash_ff;
      la_in         = la_ff;
      cnt_in        = cnt_ff;
      saved_hash_in = saved_hash_ff;
      saved_la_in   = saved_la_ff;
      saved_cnt_in  = saved_cnt_ff;
      started_in    = started_ff;
      space_in      = space_ff;
      phase_in      = phase_ff;
      num_valid_in  = num_valid_ff;
      neg_in        = neg_ff;
      mag_in        = mag_ff;
      q_pop         = 1'b0;
      case (state_ff)
         ST_RUN: begin
            if (q_valid) begin
               q_pop = 1'b1;
               if (!q_data.empty_text) begin
                  if (!started_ff) begin
                     if (!q_data.blank) begin
                        started_in   = 1'b1;
                        hash_in      = dec_hash;
                        la_in        = dec_la;
                        cnt_in       = dec_cnt;
                        phase_in     = phase_n;
                        num_valid_in = num_valid_n;
                        neg_in       = neg_n;
                        mag_in       = mag_n;
                     end
                  end else if (q_data.blank) begin
                     if (!space_ff) begin
                        saved_hash_in = hash_ff;
                        saved_la_in   = la_ff;
                        saved_cnt_in  = cnt_ff;
                        space_in      = 1'b1;
                     end
                     hash_in = dec_hash;
                     la_in   = dec_la;
                     cnt_in  = dec_cnt;
                  end else begin
                     space_in     = 1'b0;
                     hash_in      = dec_hash;
                     la_in        = dec_la;
                     cnt_in       = dec_cnt;
                     phase_in     = phase_n;
                     num_valid_in = num_valid_n;
                     neg_in       = neg_n;
                     mag_in       = mag_n;
                  end
               end
               if (q_data.last_byte) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            if (rsp_load) begin
               state_in      = ST_RUN;
               hash_in       = '0;
               la_in         = '{default: 8'd0};
               cnt_in        = '0;
               saved_hash_in = '0;
               saved_la_in   = '{default: 8'd0};
               saved_cnt_in  = '0;
               started_in    = 1'b0;
               space_in      = 1'b0;
               phase_in      = PH_START;
               num_valid_in  = 1'b1;
               neg_in        = 1'b0;
               mag_in        = '0;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_RUN;
         hash_ff       <= '0;
         la_ff         <= '{default: 8'd0};
         cnt_ff        <= '0;
         saved_hash_ff <= '0;
         saved_la_ff   <= '{default: 8'd0};
         saved_cnt_ff  <= '0;
         started_ff    <= 1'b0;
         space_ff      <= 1'b0;
         phase_ff      <= PH_START;
         num_valid_ff  <= 1'b1;
         neg_ff        <= 1'b0;
         mag_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         hash_ff       <= hash_in;
         la_ff         <= la_in;
         cnt_ff        <= cnt_in;
         saved_hash_ff <= saved_hash_in;
         saved_la_ff   <= saved_la_in;
         saved_cnt_ff  <= saved_cnt_in;
         started_ff    <= started_in;
         space_ff      <= space_in;
         phase_ff      <= phase_in;
         num_valid_ff  <= num_valid_in;
         neg_ff        <= neg_in;
         mag_ff        <= mag_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_seed_ff    <= res_seed;
         rsp_present_ff <= res_present;
         rsp_source_ff  <= res_source;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_seed         = rsp_seed_ff;
   assign rsp_seed_present = rsp_present_ff;
   assign rsp_seed_source  = rsp_source_ff;

endmodule

### dv/text_seed_parse_or_hash_test.sv
// Self-checking testbench for text_seed_parse_or_hash: directed texts from a table, then
// random numbers, UTF-8 text and noise, with random idling on both channels.
// Depends on tsph_pkg and the text_seed_parse_or_hash RTL.
module text_seed_parse_or_hash_test;
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [1:0] {PH_SIGN, PH_PLUS, PH_MINUS, PH_DIGITS} num_phase_type;

   typedef struct packed {
      logic [63:0] seed;
      logic        present;
      logic        source;
   } seed_result_type;

   typedef struct packed {
      logic [159:0]    text;
      logic [4:0]      len;
      logic            lead_empty;
      logic            tail_empty;
      logic            typed;
      seed_result_type want;
   } text_row_type;

   localparam logic SRC_DECIMAL = 1'b0;
   localparam logic SRC_HASH    = 1'b1;
   localparam logic [63:0] NEG_LIM = 64'h8000_0000_0000_0000;
   localparam logic [63:0] POS_LIM = 64'h7FFF_FFFF_FFFF_FFFF;

   localparam text_row_type DIRECTED_ROWS [9] = '{
      '{160'd0, 5'd0, 1'b0, 1'b1, 1'b1, '{64'd0, 1'b0, SRC_DECIMAL}},
      '{{tsph_pkg::CHAR_TAB, tsph_pkg::CHAR_SPACE}, 5'd2, 1'b0, 1'b0, 1'b1,
        '{64'd0, 1'b0, SRC_DECIMAL}},
      '{{8'h00}, 5'd1, 1'b0, 1'b0, 1'b1, '{64'd0, 1'b1, SRC_HASH}},
      '{{8'hFF}, 5'd1, 1'b0, 1'b0, 1'b1, '{64'd255, 1'b1, SRC_HASH}},
      '{{8'hF0, 8'h9F, 8'h98, 8'h80}, 5'd4, 1'b0, 1'b0, 1'b0, '{64'd0, 1'b0, SRC_DECIMAL}},
      '{{8'hE2, 8'h82, tsph_pkg::CHAR_SPACE}, 5'd3, 1'b0, 1'b0, 1'b0,
        '{64'd0, 1'b0, SRC_DECIMAL}},
      '{"1 2", 5'd3, 1'b0, 1'b0, 1'b0, '{64'd0, 1'b0, SRC_DECIMAL}},
      '{"+-5", 5'd3, 1'b1, 1'b1, 1'b0, '{64'd0, 1'b0, SRC_DECIMAL}},
      '{"9223372036854775808", 5'd19, 1'b0, 1'b0, 1'b0, '{64'd0, 1'b0, SRC_DECIMAL}}
   };

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_text_byte;
   logic        req_last_byte;
   logic        req_empty_text;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [63:0] rsp_seed;
   logic        rsp_seed_present;
   logic        rsp_seed_source;

   text_seed_parse_or_hash dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_text_byte    (req_text_byte),
      .req_last_byte    (req_last_byte),
      .req_empty_text   (req_empty_text),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_seed         (rsp_seed),
      .rsp_seed_present (rsp_seed_present),
      .rsp_seed_source  (rsp_seed_source)
   );

   always #5 clock = ~clock;

   seed_result_type seeds_due [$];
   int  mismatches = 0;
   int  sent = 0;
   bit  calm = 1'b0;
   bit  hold_off_req = 1'b0;

   // Text state of the predictor
   logic [31:0]   h_live, h_saved;
   logic [7:0]    grp [3];
   logic [7:0]    grp_saved [3];
   logic [1:0]    grp_n, saved_n;
   logic          started, trailing;
   num_phase_type num_phase;
   logic          num_ok, num_neg;
   logic [63:0]   num_mag;

   function automatic void clear_text();
      h_live = '0;
      h_saved = '0;
      grp = '{default: 8'd0};
      grp_saved = '{default: 8'd0};
      grp_n = '0;
      saved_n = '0;
      started = 1'b0;
      trailing = 1'b0;
      num_phase = PH_SIGN;
      num_ok = 1'b1;
      num_neg = 1'b0;
      num_mag = '0;
   endfunction

   function automatic logic [31:0] mix_cp(input logic [31:0] h, input logic [31:0] cp);
      logic [31:0] v;
      if (cp >= 32'h10000) begin
         v = cp - 32'h10000;
         h = h * 32'd31 + (32'hD800 + (v >> 10));
         h = h * 32'd31 + (32'hDC00 + (v & 32'h3FF));
      end else begin
         h = h * 32'd31 + cp;
      end
      return h;
   endfunction

   function automatic int group_len(input logic [7:0] lead);
      if (lead >= 8'hF0) return 4;
      if (lead >= 8'hE0) return 3;
      if (lead >= 8'hC0) return 2;
      return 1;
   endfunction

   function automatic logic [31:0] unpack_cp(input int n, input logic [7:0] b0,
                                             input logic [7:0] b1, input logic [7:0] b2,
                                             input logic [7:0] b3);
      if (n >= 4) return {11'd0, b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
      if (n == 3) return {16'd0, b0[3:0], b1[5:0], b2[5:0]};
      if (n == 2) return {21'd0, b0[4:0], b1[5:0]};
      return {24'd0, b0};
   endfunction

   function automatic void utf_push(input logic [7:0] b);
      int len;
      logic [31:0] cp;
      if (grp_n == 2'd0) begin
         len = group_len(b);
         if (len == 1) begin
            h_live = mix_cp(h_live, {24'd0, b});
         end else begin
            grp[0] = b;
            grp_n = 2'd1;
         end
      end else begin
         len = group_len(grp[0]);
         if (int'(grp_n) + 1 >= len) begin
            case (len)
               4: cp = unpack_cp(4, grp[0], grp[1], grp[2], b);
               3: cp = unpack_cp(3, grp[0], grp[1], b, 8'd0);
               default: cp = unpack_cp(2, grp[0], b, 8'd0, 8'd0);
            endcase
            h_live = mix_cp(h_live, cp);
            grp_n = 2'd0;
         end else begin
            grp[grp_n] = b;
            grp_n = grp_n + 2'd1;
         end
      end
   endfunction

   function automatic void number_push(input logic [7:0] c);
      logic        digit;
      logic [63:0] d, lim;
      digit = (c >= tsph_pkg::CHAR_ZERO) && (c <= tsph_pkg::CHAR_NINE);
      if (!num_ok) return;
      if (num_phase == PH_SIGN && c == tsph_pkg::CHAR_PLUS) begin
         num_phase = PH_PLUS;
      end else if ((num_phase == PH_SIGN || num_phase == PH_PLUS) &&
                   c == tsph_pkg::CHAR_MINUS) begin
         num_neg = 1'b1;
         num_phase = PH_MINUS;
      end else if (digit) begin
         d = {56'd0, c - tsph_pkg::CHAR_ZERO};
         lim = num_neg ? NEG_LIM : POS_LIM;
         if (num_mag > (lim - d) / 64'd10) begin
            num_ok = 1'b0;
         end else begin
            num_mag = num_mag * 64'd10 + d;
            num_phase = PH_DIGITS;
         end
      end else begin
         num_ok = 1'b0;
      end
   endfunction

   function automatic void track_seed_byte(input logic [7:0] b, input logic l, input logic e,
                                           output bit got, output seed_result_type res);
      logic        blank;
      logic [31:0] h;
      logic [1:0]  n;
      logic [7:0]  g [3];
      blank = (b == tsph_pkg::CHAR_SPACE) || (b == tsph_pkg::CHAR_TAB);
      got = 1'b0;
      res = '0;
      if (!e) begin
         if (!started) begin
            if (!blank) begin
               started = 1'b1;
               utf_push(b);
               number_push(b);
            end
         end else if (blank) begin
            if (!trailing) begin
               h_saved = h_live;
               grp_saved = grp;
               saved_n = grp_n;
               trailing = 1'b1;
            end
            utf_push(b);
         end else begin
            if (trailing) num_ok = 1'b0;
            trailing = 1'b0;
            utf_push(b);
            number_push(b);
         end
      end
      if (l) begin
         got = 1'b1;
         if (started) begin
            res.present = 1'b1;
            if (num_ok && num_phase == PH_DIGITS) begin
               res.seed = num_neg ? 64'd0 - num_mag : num_mag;
               res.source = SRC_DECIMAL;
            end else begin
               if (trailing) begin
                  h = h_saved;
                  n = saved_n;
                  g = grp_saved;
               end else begin
                  h = h_live;
                  n = grp_n;
                  g = grp;
               end
               if (n != 2'd0) h = mix_cp(h, unpack_cp(int'(n), g[0], g[1], g[2], 8'd0));
               res.seed = {{32{h[31]}}, h};
               res.source = SRC_HASH;
            end
         end
         clear_text();
      end
   endfunction

   task automatic offer(input logic [7:0] b, input logic l, input logic e, input bit typed,
                        input seed_result_type typed_res);
      int gap;
      bit got;
      seed_result_type res;
      if (!calm && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 7);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_text_byte <= b;
      req_last_byte <= l;
      req_empty_text <= e;
      do @(posedge clock); while (req_stall);
      track_seed_byte(b, l, e, got, res);
      if (got) seeds_due.insert(seeds_due.size(), typed ? typed_res : res);
      sent++;
   endtask

   task automatic send_text(input logic [7:0] txt [$], input bit lead_empty, input bit tail_empty,
                            input bit typed, input seed_result_type want);
      int i;
      if (lead_empty) offer(8'($urandom_range(0, 255)), 1'b0, 1'b1, typed, want);
      for (i = 0; i < txt.size(); i++)
         offer(txt[i], (i == txt.size() - 1) && !tail_empty, 1'b0, typed, want);
      if (tail_empty || txt.size() == 0)
         offer(8'($urandom_range(0, 255)), 1'b1, 1'b1, typed, want);
   endtask

   function automatic logic [7:0] blank_byte();
      return ($urandom_range(0, 1) == 0) ? tsph_pkg::CHAR_SPACE : tsph_pkg::CHAR_TAB;
   endfunction

   function automatic logic [7:0] digit_byte();
      return tsph_pkg::CHAR_ZERO + 8'($urandom_range(0, 9));
   endfunction

   function automatic logic [7:0] cont_byte();
      if ($urandom_range(0, 5) == 0) return 8'($urandom_range(0, 255));
      return 8'h80 | 8'($urandom_range(0, 63));
   endfunction

   task automatic random_text();
      logic [7:0] txt [$];
      int  kind, n, i;
      bit  tail;
      string lim;
      lim = "922337203685477580";
      kind = $urandom_range(0, 9);
      tail = ($urandom_range(0, 7) == 0);
      repeat ($urandom_range(0, 2)) txt.insert(txt.size(), blank_byte());
      case (kind)
         0, 1, 2, 3: begin
            if ($urandom_range(0, 3) == 0) txt.insert(txt.size(), tsph_pkg::CHAR_PLUS);
            if ($urandom_range(0, 2) == 0) txt.insert(txt.size(), tsph_pkg::CHAR_MINUS);
            n = $urandom_range(1, ($urandom_range(0, 5) == 0) ? 19 : 6);
            repeat (n) txt.insert(txt.size(), digit_byte());
         end
         4: begin
            if ($urandom_range(0, 1) == 0) txt.insert(txt.size(), tsph_pkg::CHAR_MINUS);
            if ($urandom_range(0, 3) == 0) txt.insert(txt.size(), tsph_pkg::CHAR_ZERO);
            for (i = 0; i < lim.len(); i++) txt.insert(txt.size(), lim[i]);
            txt.insert(txt.size(), tsph_pkg::CHAR_ZERO + 8'($urandom_range(6, 9)));
            if ($urandom_range(0, 4) == 0) txt.insert(txt.size(), digit_byte());
         end
         5, 6: begin
            repeat ($urandom_range(1, 5)) begin
               case ($urandom_range(0, 4))
                  0: txt.insert(txt.size(), 8'($urandom_range(8'h21, 8'h7E)));
                  1: begin
                     txt.insert(txt.size(), 8'hC0 | 8'($urandom_range(0, 31)));
                     txt.insert(txt.size(), cont_byte());
                  end
                  2: begin
                     txt.insert(txt.size(), 8'hE0 | 8'($urandom_range(0, 15)));
                     repeat (2) txt.insert(txt.size(), cont_byte());
                  end
                  3: begin
                     txt.insert(txt.size(), 8'hF0 | 8'($urandom_range(0, 15)));
                     repeat (3) txt.insert(txt.size(), cont_byte());
                  end
                  default: txt.insert(txt.size(), blank_byte());
               endcase
            end
            // sometimes drop one or two trailing bytes, which can cut the last group short
            if ($urandom_range(0, 2) == 0) begin
               n = $urandom_range(1, 2);
               while (n > 0 && txt.size() > 1) begin
                  void'(txt.pop_back());
                  n--;
               end
            end
         end
         7: begin
            repeat ($urandom_range(1, 4)) txt.insert(txt.size(), digit_byte());
            case ($urandom_range(0, 3))
               0: txt.insert(txt.size(), blank_byte());
               1: txt.insert(txt.size(), tsph_pkg::CHAR_PLUS);
               2: txt.insert(txt.size(), tsph_pkg::CHAR_MINUS);
               default: txt.insert(txt.size(), 8'($urandom_range(8'h41, 8'h7A)));
            endcase
            repeat ($urandom_range(1, 3)) txt.insert(txt.size(), digit_byte());
         end
         default: begin
            repeat ($urandom_range(0, 6))
               txt.insert(txt.size(), ($urandom_range(0, 2) == 0) ? blank_byte() :
                                      8'($urandom_range(0, 255)));
         end
      endcase
      repeat ($urandom_range(0, 2)) txt.insert(txt.size(), blank_byte());
      send_text(txt, $urandom_range(0, 5) == 0, tail, 1'b0, '0);
   endtask

   initial begin
      logic [7:0] txt [$];
      text_row_type row;
      int i;
      bit hold_asked;
      hold_asked = 1'b0;
      clear_text();
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_text_byte <= 8'd0;
      req_last_byte <= 1'b0;
      req_empty_text <= 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[r]) begin
         row = DIRECTED_ROWS[r];
         txt.delete();
         for (i = 0; i < int'(row.len); i++)
            txt.insert(txt.size(), row.text[8 * (int'(row.len) - 1 - i) +: 8]);
         send_text(txt, row.lead_empty, row.tail_empty, row.typed, row.want);
      end

      while (sent < 950) begin
         if (!hold_asked && sent > 300) begin
            hold_asked = 1'b1;
            hold_off_req = 1'b1;
         end
         if (sent > 830) calm = 1'b1;
         random_text();
      end
      req_valid <= 1'b0;

      while (seeds_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin
      int n;
      rsp_stall <= 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            // hold off long enough to back up the queue into the request side
            hold_off_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (400) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 7);
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      seed_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (seeds_due.size() == 0) begin
            $display("%0t: unexpected result seed %h present %b source %b", $realtime,
                     rsp_seed, rsp_seed_present, rsp_seed_source);
            mismatches++;
         end else begin
            want = seeds_due.pop_front();
            if ({rsp_seed, rsp_seed_present, rsp_seed_source} !== want) begin
               $display("%0t: seed mismatch expected %h/%b/%b actual %h/%b/%b", $realtime,
                        want.seed, want.present, want.source,
                        rsp_seed, rsp_seed_present, rsp_seed_source);
               mismatches++;
            end
         end
      end
   end

   initial begin
      #3000000;
      $display("Mismatches found");
      $finish;
   end

endmodule

### files.f
rtl/tsph_pkg.sv
rtl/tsph_front.sv
rtl/tsph_fifo.sv
rtl/tsph_back.sv
rtl/text_seed_parse_or_hash.sv
dv/text_seed_parse_or_hash_test.sv
